// ----- design/rtp_nack_list_generator_defines.svh -----
// ---------------------------------------------------------------------------
// NACK list generator assertion macros
// Concurrent assertion wrappers, removed for synthesis.
// ---------------------------------------------------------------------------
`ifndef RTP_NACK_LIST_GENERATOR_DEFINES_SVH
`define RTP_NACK_LIST_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define NACK_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NACK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NACK_ASSERT_IMPL(label, ante, cons)
`define NACK_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- design/nack_pkg.sv -----
// ---------------------------------------------------------------------------
// NACK list generator package
// Shared widths, table geometry and controller/datapath command types.
// ---------------------------------------------------------------------------
package nack_pkg;
  localparam int TableDepth = 64;
  localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int SeqW       = 16;
  localparam int TimeW      = 32;
  localparam int RetryW     = 8;
  localparam int RttW       = 16;
  localparam int CfgW       = 16;
  localparam int CfgIdxW    = 1;

  localparam logic [CfgIdxW-1:0] CFG_RTT   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_RETRY = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic latch;      // capture input beat
    logic set_high;   // highest_seq <= seq, started <= 1
    logic scan_clr;   // clear scan counter and accumulators
    logic scan_step;  // look at one table entry
    logic scan_mode;  // 0: find / min search, 1: tick update
    logic del_hit;    // drop the matched entry
    logic ins_write;  // write candidate into found slot
    logic cand_next;  // advance insertion candidate
    logic emit_find;  // reset emit search
    logic emit_step;  // scan for next larger listed seq
    logic emit_out;   // present one result
  } nack_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_tick;
    logic first_pkt;
    logic is_dup;
    logic is_old;
    logic scan_done;
    logic hit;
    logic has_gap;
    logic cand_last;
    logic emit_found;
  } nack_sts_t;
endpackage

// ----- design/nack_datapath.sv -----
// ---------------------------------------------------------------------------
// NACK datapath
// Entry table, scan counter, insertion candidate and ordered emit search.
// ---------------------------------------------------------------------------
module nack_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_func,
  input  logic [nack_pkg::SeqW-1:0]     in_seq_num,
  input  logic [nack_pkg::TimeW-1:0]    in_now_ms,
  input  logic [nack_pkg::RttW-1:0]     rtt_ms,
  input  logic [nack_pkg::RetryW-1:0]   retry_limit,
  input  nack_pkg::nack_cmd_t           cmd,
  output nack_pkg::nack_sts_t           sts,
  output logic [nack_pkg::SeqW-1:0]     out_nacked_seq,
  output logic                          out_last_of_run
);
  import nack_pkg::*;

  // entry table; valid bits and list marks reset, payload not
  logic [TableDepth-1:0] valid_r, valid_nxt;
  logic [TableDepth-1:0] listed_r, listed_nxt;
  logic [SeqW-1:0]   eseq_r   [TableDepth];
  logic [RetryW-1:0] eretry_r [TableDepth];
  logic [TimeW-1:0]  etime_r  [TableDepth];

  logic             func_r;
  logic [SeqW-1:0]  seq_r;
  logic [TimeW-1:0] now_r;
  logic             started_r;
  logic [SeqW-1:0]  high_r;
  logic [CntW-1:0]  cnt_r;
  logic [IdxW-1:0]  idx;
  // registered table read, processed in the cycle after the address
  logic [SeqW-1:0]   rd_seq_r;
  logic [RetryW-1:0] rd_retry_r;
  logic [TimeW-1:0]  rd_time_r;
  logic [IdxW-1:0]   rd_idx_r;
  logic              rd_find_r;
  logic              rd_tick_r;
  logic              rd_emit_r;
  // find/min search results
  logic             hit_r;
  logic [IdxW-1:0]  hit_idx_r;
  logic             free_r;
  logic [IdxW-1:0]  free_idx_r;
  logic [SeqW-1:0]  min_seq_r;
  logic [IdxW-1:0]  min_idx_r;
  logic             min_ok_r;
  // gap candidate: seq_r - k_r
  logic [CntW-1:0]  k_r;
  logic [SeqW-1:0]  cand;
  // emit search
  logic [SeqW-1:0]  prev_r;
  logic             prev_ok_r;
  logic [SeqW-1:0]  best_r;
  logic [IdxW-1:0]  best_idx_r;
  logic             best_ok_r;
  logic [SeqW-1:0]  key;
  logic [SeqW-1:0]  back;
  logic [SeqW-1:0]  gap;
  logic [IdxW-1:0]  wr_idx;
  logic             sel_ok;
  logic [TimeW-1:0] age;

  assign idx  = cnt_r[IdxW-1:0];
  assign cand = seq_r - SeqW'(k_r);
  assign key  = (func_r) ? best_r : cand;
  assign back = high_r - seq_r;
  assign gap  = seq_r - high_r - 16'd1;
  assign age  = now_r - rd_time_r;
  assign wr_idx = free_r ? free_idx_r : min_idx_r;
  assign sel_ok = listed_r[rd_idx_r] && (!prev_ok_r || rd_seq_r > prev_r) &&
                  (!best_ok_r || rd_seq_r < best_r);

  // status
  always_comb begin
    sts.is_tick    = func_r;
    sts.first_pkt  = !started_r;
    sts.is_dup     = seq_r == high_r;
    sts.is_old     = back >= 16'd1 && back <= 16'h7FFF;
    sts.scan_done  = cnt_r == CntW'(TableDepth);
    sts.hit        = hit_r;
    sts.has_gap    = k_r != '0;
    sts.cand_last  = k_r == CntW'(1);
    // last entry of the search is still in the read stage at scan end
    sts.emit_found = best_ok_r || (rd_emit_r && sel_ok);
  end

  always_comb begin
    valid_nxt  = valid_r;
    listed_nxt = listed_r;
    if (rd_tick_r && valid_r[rd_idx_r]) begin
      if (rd_retry_r > retry_limit) valid_nxt[rd_idx_r] = 1'b0;
      else if (age >= TimeW'(rtt_ms)) listed_nxt[rd_idx_r] = 1'b1;
    end
    if (cmd.del_hit) valid_nxt[hit_idx_r] = 1'b0;
    if (cmd.ins_write && !hit_r && (free_r || min_ok_r)) valid_nxt[wr_idx] = 1'b1;
    if (cmd.emit_out) listed_nxt[best_idx_r] = 1'b0;
  end

  // control-bearing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      listed_r  <= '0;
      started_r <= 1'b0;
      high_r    <= '0;
      cnt_r     <= '0;
      rd_find_r <= 1'b0;
      rd_tick_r <= 1'b0;
      rd_emit_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      listed_r <= listed_nxt;
      if (cmd.set_high) begin
        started_r <= 1'b1;
        high_r    <= seq_r;
      end
      if (cmd.scan_clr || cmd.emit_find) cnt_r <= '0;
      else if (cmd.scan_step || cmd.emit_step) cnt_r <= cnt_r + CntW'(1);
      rd_find_r <= cmd.scan_step && !cmd.scan_mode;
      rd_tick_r <= cmd.scan_step && cmd.scan_mode;
      rd_emit_r <= cmd.emit_step;
    end
  end

  // payload and search registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_func;
      seq_r  <= in_seq_num;
      now_r  <= in_now_ms;
      k_r    <= '0;
      prev_ok_r <= 1'b0;
    end
    if (cmd.set_high && !func_r) begin
      // gap length clipped to table depth
      k_r <= (gap < SeqW'(TableDepth)) ? CntW'(gap) : CntW'(TableDepth);
    end
    if (cmd.cand_next) k_r <= k_r - CntW'(1);
    // table read stage
    if (cmd.scan_step || cmd.emit_step) begin
      rd_seq_r   <= eseq_r[idx];
      rd_retry_r <= eretry_r[idx];
      rd_time_r  <= etime_r[idx];
      rd_idx_r   <= idx;
    end
    if (cmd.scan_clr) begin
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
      min_ok_r <= 1'b0;
      hit_idx_r <= '0;
      free_idx_r <= '0;
      min_idx_r <= '0;
      min_seq_r <= '0;
    end
    if (rd_find_r) begin
      if (valid_r[rd_idx_r] && rd_seq_r == key && !hit_r) begin
        hit_r <= 1'b1;
        hit_idx_r <= rd_idx_r;
      end
      if (!valid_r[rd_idx_r] && !free_r) begin
        free_r <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
      if (valid_r[rd_idx_r] && (!min_ok_r || rd_seq_r < min_seq_r)) begin
        min_ok_r <= 1'b1;
        min_seq_r <= rd_seq_r;
        min_idx_r <= rd_idx_r;
      end
    end
    if (rd_tick_r && valid_r[rd_idx_r] &&
        rd_retry_r <= retry_limit && age >= TimeW'(rtt_ms)) begin
      etime_r[rd_idx_r] <= now_r;
      if (rd_retry_r != 8'hFF) eretry_r[rd_idx_r] <= rd_retry_r + 8'd1;
    end
    if (cmd.ins_write && !hit_r && (free_r || min_ok_r)) begin
      eseq_r[wr_idx]   <= cand;
      eretry_r[wr_idx] <= '0;
      etime_r[wr_idx]  <= '0;
    end
    if (cmd.emit_find) begin
      best_ok_r <= 1'b0;
      best_r    <= '0;
      best_idx_r <= '0;
    end
    if (rd_emit_r && sel_ok) begin
      best_ok_r  <= 1'b1;
      best_r     <= rd_seq_r;
      best_idx_r <= rd_idx_r;
    end
    if (cmd.emit_out) begin
      prev_ok_r <= 1'b1;
      prev_r    <= best_r;
    end
  end

  assign out_nacked_seq  = best_r;
  assign out_last_of_run = listed_nxt == '0;
endmodule

// ----- design/nack_ctrl.sv -----
// ---------------------------------------------------------------------------
// NACK controller
// Sequences packet handling, gap insertion and tick scan/emit.
// ---------------------------------------------------------------------------
module nack_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  nack_pkg::nack_sts_t sts,
  output nack_pkg::nack_cmd_t cmd,
  output logic                out_valid
);
  import nack_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_OLDS  = 4'd2;
  localparam logic [3:0] S_OLDD  = 4'd3;
  localparam logic [3:0] S_GAP   = 4'd4;
  localparam logic [3:0] S_INSS  = 4'd5;
  localparam logic [3:0] S_INSW  = 4'd6;
  localparam logic [3:0] S_TICK  = 4'd7;
  localparam logic [3:0] S_EFIND = 4'd8;
  localparam logic [3:0] S_EOUT  = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.scan_clr = 1'b1;
        if (sts.is_tick) state_nxt = S_TICK;
        else if (sts.first_pkt) begin
          cmd.set_high = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.is_dup) state_nxt = S_IDLE;
        else if (sts.is_old) state_nxt = S_OLDS;
        else begin
          cmd.set_high = 1'b1;
          state_nxt = S_GAP;
        end
      end
      S_OLDS: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.scan_step = 1'b0;
          state_nxt = S_OLDD;
        end
      end
      S_OLDD: begin
        cmd.del_hit = sts.hit;
        state_nxt = S_IDLE;
      end
      S_GAP: begin
        cmd.scan_clr = 1'b1;
        state_nxt = sts.has_gap ? S_INSS : S_IDLE;
      end
      S_INSS: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.scan_step = 1'b0;
          state_nxt = S_INSW;
        end
      end
      S_INSW: begin
        cmd.ins_write = 1'b1;
        cmd.scan_clr = 1'b1;
        cmd.cand_next = 1'b1;
        state_nxt = sts.cand_last ? S_IDLE : S_INSS;
      end
      S_TICK: begin
        cmd.scan_step = 1'b1;
        cmd.scan_mode = 1'b1;
        if (sts.scan_done) begin
          cmd.scan_step = 1'b0;
          cmd.emit_find = 1'b1;
          state_nxt = S_EFIND;
        end
      end
      S_EFIND: begin
        cmd.emit_step = 1'b1;
        if (sts.scan_done) begin
          cmd.emit_step = 1'b0;
          state_nxt = sts.emit_found ? S_EOUT : S_IDLE;
        end
      end
      S_EOUT: begin
        cmd.emit_out = 1'b1;
        cmd.emit_find = 1'b1;
        out_valid = 1'b1;
        state_nxt = S_EFIND;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = state_r != S_IDLE;
endmodule

// ----- design/rtp_nack_list_generator.sv -----
// ---------------------------------------------------------------------------
// RTP NACK list generator
// Missing-sequence table with tick-driven ordered retransmit requests.
// ---------------------------------------------------------------------------
// Busy after accept while handling: an old packet scans the table once, a
// forward jump scans once per inserted number (at most 64 numbers).
// Tick: an update scan, one search per request, then a closing search;
// one item at a time, no stall.
// Synchronous active-low reset empties the table, clears started, loads
// rtt_ms=100 and retry_limit=10.
`include "rtp_nack_list_generator_defines.svh"
module rtp_nack_list_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_func,
  input  logic [nack_pkg::SeqW-1:0]     in_seq_num,
  input  logic [nack_pkg::TimeW-1:0]    in_now_ms,
  output logic                          out_valid,
  output logic [nack_pkg::SeqW-1:0]     out_nacked_seq,
  output logic                          out_last_of_run,
  input  logic                          cfg_we,
  input  logic [nack_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [nack_pkg::CfgW-1:0]     cfg_data
);
  import nack_pkg::*;

  logic [RttW-1:0]   rtt_ms_r;
  logic [RetryW-1:0] retry_limit_r;
  nack_cmd_t cmd;
  nack_sts_t sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rtt_ms_r      <= 16'd100;
      retry_limit_r <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RTT:   rtt_ms_r <= cfg_data;
        CFG_RETRY: retry_limit_r <= cfg_data[RetryW-1:0];
        default: ;
      endcase
    end
  end

  nack_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .sts, .cmd, .out_valid
  );

  nack_datapath u_dp (
    .clk, .rst_n, .in_func, .in_seq_num, .in_now_ms,
    .rtt_ms(rtt_ms_r), .retry_limit(retry_limit_r),
    .cmd, .sts, .out_nacked_seq, .out_last_of_run
  );

  `NACK_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `NACK_ASSERT_IMPL(a_out_busy, out_valid, busy)
  `NACK_ASSERT_NEXT(a_last_idle, out_valid && out_last_of_run, !out_valid)
endmodule

// ----- tb/tb_top.sv -----
// ---------------------------------------------------------------------------
// NACK list generator testbench
// Drives packet and tick beats into the missing-sequence table, predicts the
// ordered retransmit requests of every tick and compares them field by field.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  Depth     = nack_pkg::TableDepth;
  localparam bit  FUNC_PKT  = 1'b0;
  localparam bit  FUNC_TICK = 1'b1;
  localparam int  IdleLimit = 30000;

  typedef logic [nack_pkg::SeqW-1:0]  seq_t;
  typedef logic [nack_pkg::TimeW-1:0] ms_t;

  typedef struct {
    seq_t nacked;
    logic last;
  } nack_beat_t;

  // directed row: n_typed < 0 means the predictor supplies the expectation
  typedef struct {
    bit   func;
    seq_t seq;
    ms_t  now;
    int   n_typed;
    seq_t s0;
    seq_t s1;
  } dir_row_t;

  logic clk, rst_n, start, busy;
  logic in_func;
  seq_t in_seq_num;
  ms_t  in_now_ms;
  logic out_valid, out_last_of_run;
  seq_t out_nacked_seq;
  logic cfg_we;
  logic [nack_pkg::CfgIdxW-1:0] cfg_index;
  logic [nack_pkg::CfgW-1:0]    cfg_data;

  rtp_nack_list_generator u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_seq_num(in_seq_num), .in_now_ms(in_now_ms),
    .out_valid(out_valid), .out_nacked_seq(out_nacked_seq),
    .out_last_of_run(out_last_of_run),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // shadow table and configuration
  logic [15:0] rtt_cfg;
  logic [7:0]  retry_cfg;
  bit          seen_first;
  seq_t        top_seq;
  bit          miss_valid [Depth];
  seq_t        miss_seq   [Depth];
  logic [7:0]  miss_retry [Depth];
  ms_t         miss_sent  [Depth];

  nack_beat_t  pending_nacks[$];
  int          n_errors;
  int          idle_cycles;
  bit          no_idle;
  ms_t         clock_ms;

  function automatic int find_missing(seq_t s);
    for (int i = 0; i < Depth; i++)
      if (miss_valid[i] && miss_seq[i] == s) return i;
    return -1;
  endfunction

  function automatic void add_missing(seq_t s);
    int slot;
    slot = -1;
    if (find_missing(s) >= 0) return;
    for (int i = 0; i < Depth && slot < 0; i++)
      if (!miss_valid[i]) slot = i;
    // table full: evict the numerically smallest number
    if (slot < 0) begin
      slot = 0;
      for (int i = 1; i < Depth; i++)
        if (miss_seq[i] < miss_seq[slot]) slot = i;
    end
    miss_valid[slot] = 1'b1;
    miss_seq[slot]   = s;
    miss_retry[slot] = '0;
    miss_sent[slot]  = '0;
  endfunction

  function automatic void track_packet(seq_t s);
    seq_t back;
    int   gap, k, idx;
    if (!seen_first) begin
      seen_first = 1'b1;
      top_seq = s;
      return;
    end
    if (s == top_seq) return;
    back = top_seq - s;
    if (back <= 16'h7FFF) begin
      idx = find_missing(s);
      if (idx >= 0) miss_valid[idx] = 1'b0;
      return;
    end
    gap = int'(seq_t'(s - top_seq)) - 1;
    top_seq = s;
    k = (gap < Depth) ? gap : Depth;
    for (int i = k; i >= 1; i--) add_missing(s - seq_t'(i));
  endfunction

  function automatic void track_tick(ms_t now, ref seq_t run[$]);
    run.delete();
    for (int i = 0; i < Depth; i++) begin
      if (!miss_valid[i]) continue;
      if (miss_retry[i] > retry_cfg) begin
        miss_valid[i] = 1'b0;
        continue;
      end
      if (ms_t'(now - miss_sent[i]) >= ms_t'(rtt_cfg)) begin
        miss_sent[i] = now;
        if (miss_retry[i] != 8'hFF) miss_retry[i]++;
        run.insert(run.size(), miss_seq[i]);
      end
    end
    run.sort();
  endfunction

  // append one expected request beat
  function automatic void expect_nack(seq_t s, logic last);
    nack_beat_t b;
    b.nacked = s;
    b.last   = last;
    pending_nacks.insert(pending_nacks.size(), b);
  endfunction

  // predict and queue the requests caused by one accepted beat
  function automatic void predict_beat(bit func, seq_t s, ms_t now);
    seq_t run[$];
    if (func == FUNC_PKT) track_packet(s);
    else begin
      track_tick(now, run);
      foreach (run[i]) expect_nack(run[i], i == run.size() - 1);
    end
  endfunction

  // one beat toward the block, sometimes with random idle cycles before it
  task automatic send_beat(bit func, seq_t s, ms_t now);
    if (!no_idle && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start      <= 1'b1;
    in_func    <= func;
    in_seq_num <= s;
    in_now_ms  <= now;
    do @(posedge clk); while (busy);
  endtask

  // hold off until every request has come and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_nacks.size() != 0 || busy) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_cfg(logic [15:0] rtt, logic [7:0] retry);
    cfg_we    <= 1'b1;
    cfg_index <= nack_pkg::CFG_RTT;
    cfg_data  <= rtt;
    @(posedge clk);
    cfg_index <= nack_pkg::CFG_RETRY;
    cfg_data  <= {8'h00, retry};
    @(posedge clk);
    cfg_we    <= 1'b0;
    rtt_cfg   = rtt;
    retry_cfg = retry;
  endtask

  task automatic run_random(int count);
    bit   func;
    seq_t s;
    int   r, idx;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      func = FUNC_PKT;
      s = top_seq + seq_t'($urandom_range(1, 4));
      if (r < 30) begin
        func = FUNC_TICK;
        if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
        else clock_ms += ms_t'($urandom_range(0, 2 * int'(rtt_cfg) + 10));
      end else if (r < 75) begin
        idx = $urandom_range(0, Depth - 1);
        for (int i = 0; i < Depth; i++)
          if (miss_valid[(idx + i) % Depth]) s = miss_seq[(idx + i) % Depth];
      end else if (r < 80) s = top_seq;
      else if (r < 85) s = top_seq - seq_t'($urandom_range(1, 16'h7FFF));
      else if (r < 88) s = top_seq + seq_t'($urandom_range(65, 16'hFFFF));
      else if (r < 94) s = top_seq + seq_t'($urandom_range(5, 40));
      else s = $urandom;
      if (r >= 30 && r < 60) s = top_seq + seq_t'($urandom_range(1, 4));
      send_beat(func, s, clock_ms);
      predict_beat(func, s, clock_ms);
    end
  endtask

  // checker for request beats
  always @(posedge clk) begin
    nack_beat_t want;
    if (rst_n && out_valid) begin
      if (pending_nacks.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected request seq=%h last=%b", out_nacked_seq, out_last_of_run);
      end else begin
        want = pending_nacks.pop_front();
        if (want.nacked !== out_nacked_seq || want.last !== out_last_of_run) begin
          n_errors++;
          if (n_errors <= 10)
            $display("request mismatch: exp seq=%h last=%b, got seq=%h last=%b",
                     want.nacked, want.last, out_nacked_seq, out_last_of_run);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving either way
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  dir_row_t dir_tab[13] = '{
    '{FUNC_TICK, 16'h0000, 32'd0,          0, 16'h0000, 16'h0000}, // empty table
    '{FUNC_PKT,  16'hFFFE, 32'd0,          0, 16'h0000, 16'h0000}, // first packet
    '{FUNC_PKT,  16'hFFFE, 32'd0,          0, 16'h0000, 16'h0000}, // duplicate
    '{FUNC_PKT,  16'h0001, 32'd0,          0, 16'h0000, 16'h0000}, // gap wraps zero
    '{FUNC_TICK, 16'h0000, 32'd100,        2, 16'h0000, 16'hFFFF}, // exactly rtt
    '{FUNC_TICK, 16'h0000, 32'd150,        0, 16'h0000, 16'h0000}, // within rtt
    '{FUNC_PKT,  16'h0000, 32'd0,          0, 16'h0000, 16'h0000}, // late arrival
    '{FUNC_PKT,  16'h0000, 32'd0,          0, 16'h0000, 16'h0000}, // old, not listed
    '{FUNC_TICK, 16'hFFFF, 32'd200,        1, 16'hFFFF, 16'h0000},
    '{FUNC_PKT,  16'h8001, 32'd0,         -1, 16'h0000, 16'h0000}, // half-range jump
    '{FUNC_TICK, 16'h0000, 32'hFFFF_FFF0, -1, 16'h0000, 16'h0000},
    '{FUNC_TICK, 16'h0000, 32'h0000_0050, -1, 16'h0000, 16'h0000}, // time wrap
    '{FUNC_TICK, 16'hFFFF, 32'h0000_0054, -1, 16'h0000, 16'h0000}
  };

  initial begin
    seq_t dummy[$];
    start = 1'b0; in_func = 1'b0; in_seq_num = '0; in_now_ms = '0;
    cfg_we = 1'b0; cfg_index = nack_pkg::CFG_RTT; cfg_data = '0;
    rst_n = 1'b0;
    n_errors = 0; no_idle = 1'b0; clock_ms = '0;
    rtt_cfg = 16'd100; retry_cfg = 8'd10;
    seen_first = 1'b0; top_seq = '0;
    foreach (miss_valid[i]) miss_valid[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows under reset configuration
    foreach (dir_tab[r]) begin
      send_beat(dir_tab[r].func, dir_tab[r].seq, dir_tab[r].now);
      if (dir_tab[r].n_typed < 0)
        predict_beat(dir_tab[r].func, dir_tab[r].seq, dir_tab[r].now);
      else begin
        if (dir_tab[r].func == FUNC_PKT) track_packet(dir_tab[r].seq);
        else track_tick(dir_tab[r].now, dummy);
        if (dir_tab[r].n_typed >= 1)
          expect_nack(dir_tab[r].s0, dir_tab[r].n_typed == 1);
        if (dir_tab[r].n_typed == 2)
          expect_nack(dir_tab[r].s1, 1'b1);
      end
    end
    clock_ms = 32'h54;
    run_random(60);
    drain();

    write_cfg(16'd0, 8'd0);
    run_random(60);
    drain();

    write_cfg(16'hFFFF, 8'd254);
    run_random(40);
    drain();

    // retry count climbs to saturation on a newly added missing number
    write_cfg(16'd0, 8'd254);
    send_beat(FUNC_PKT, top_seq + 16'd2, clock_ms);
    predict_beat(FUNC_PKT, top_seq + 16'd2, clock_ms);
    for (int i = 0; i < 260; i++) begin
      clock_ms += 1;
      send_beat(FUNC_TICK, 16'h0000, clock_ms);
      predict_beat(FUNC_TICK, 16'h0000, clock_ms);
    end
    drain();

    write_cfg(16'($urandom_range(1, 300)), 8'($urandom_range(1, 20)));
    no_idle = 1'b1;
    run_random(40);
    no_idle = 1'b0;
    run_random(20);
    drain();
    repeat (200) @(posedge clk);

    if (n_errors == 0 && pending_nacks.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
